### rtl/fdsr_pkg.sv
// shared widths, register codes and span record for the filled disc span rasterizer
package fdsr_pkg;

    // field widths
    localparam int CoordW   = 13;
    localparam int RadW     = 5;
    localparam int ColorW   = 32;
    localparam int RowW     = 12;
    localparam int LenW     = 13;
    localparam int AddrW    = 32;
    localparam int WidthW   = 13;
    localparam int PitchW   = 15;
    localparam int BaseW    = 30;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 30;
    localparam int SDataW   = 64;
    localparam int MDataW   = 104;

    // internal widths
    localparam int DyW    = RadW + 1;
    localparam int HwW    = RadW + 1;
    localparam int SumW   = 2 * HwW + 1;
    localparam int PosW   = CoordW + 1;
    localparam int ClipW  = PosW + 1;
    localparam int ProdW  = RowW + PitchW;
    localparam int MaxRow = (1 << RowW) - 1;

    // register reset values
    localparam logic [WidthW-1:0] ResetWidth  = 13'd640;
    localparam logic [WidthW-1:0] ResetHeight = 13'd480;
    localparam logic [PitchW-1:0] ResetPitch  = 15'd2560;
    localparam logic [BaseW-1:0]  ResetBase   = 30'd0;

    // configuration register codes
    typedef enum logic [CfgIdxW-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_ROW_PITCH     = 2'd2,
        REG_FRAME_BASE    = 2'd3
    } cfg_reg_t;

    // one clipped span, ready for the address add
    typedef struct packed {
        logic [RowW-1:0]  row;
        logic [RowW-1:0]  start;
        logic [LenW-1:0]  length;
        logic [ProdW-1:0] row_offset;
        logic             empty;
        logic             last;
    } span_t;

endpackage

### rtl/fdsr_fit_unit.sv
// shared square-and-compare unit: does cand^2 + dy^2 <= r^2 hold
module fdsr_fit_unit (
    input  logic [fdsr_pkg::HwW-1:0]  cand,
    input  logic [fdsr_pkg::RadW-1:0] dy_mag,
    input  logic [fdsr_pkg::RadW-1:0] radius,
    output logic                      fits
);
    import fdsr_pkg::*;

    logic [2*HwW-1:0]  cand_sq;
    logic [2*RadW-1:0] dy_sq;
    logic [2*RadW-1:0] r_sq;
    logic [SumW-1:0]   lhs;
    logic [SumW-1:0]   rhs;

    // squares of narrow operands
    assign cand_sq = cand * cand;
    assign dy_sq   = dy_mag * dy_mag;
    assign r_sq    = radius * radius;

    // sum and compare
    assign lhs  = SumW'(cand_sq) + SumW'(dy_sq);
    assign rhs  = SumW'(r_sq);
    assign fits = (lhs <= rhs);

endmodule

### rtl/fdsr_clip_unit.sv
// clips one row of the disc to the screen and registers the span record
module fdsr_clip_unit (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [fdsr_pkg::CoordW-1:0] center_x,
    input  logic signed [fdsr_pkg::CoordW-1:0] center_y,
    input  logic signed [fdsr_pkg::DyW-1:0]   dy,
    input  logic [fdsr_pkg::HwW-1:0]          hw,
    input  logic                              last,
    input  logic [fdsr_pkg::WidthW-1:0]       screen_width,
    input  logic [fdsr_pkg::WidthW-1:0]       screen_height,
    input  logic [fdsr_pkg::PitchW-1:0]       row_pitch,
    output fdsr_pkg::span_t                   span
);
    import fdsr_pkg::*;

    logic signed [PosW-1:0]  row_s;
    logic signed [PosW-1:0]  hw_s;
    logic signed [PosW-1:0]  x1;
    logic signed [PosW-1:0]  x2;
    logic signed [ClipW-1:0] w_s;
    logic signed [ClipW-1:0] h_s;
    logic signed [ClipW-1:0] x1_c;
    logic signed [ClipW-1:0] x2_c;
    logic                    empty;
    logic [ProdW-1:0]        prod;
    logic [ClipW-1:0]        len_wide;
    span_t                   span_reg;

    // raw span edges and row
    assign hw_s  = $signed(PosW'({1'b0, hw}));
    assign row_s = PosW'(center_y) + PosW'(dy);
    assign x1    = PosW'(center_x) - hw_s;
    assign x2    = PosW'(center_x) + hw_s + PosW'(1);

    // clip against the screen edges
    assign w_s  = $signed(ClipW'({2'b00, screen_width}));
    assign h_s  = $signed(ClipW'({2'b00, screen_height}));
    assign x1_c = (x1 < 0) ? ClipW'(0) : ClipW'(x1);
    assign x2_c = (ClipW'(x2) > w_s) ? w_s : ClipW'(x2);

    assign empty = (row_s < 0) || (ClipW'(row_s) >= h_s)
                || (ClipW'(row_s) > ClipW'(MaxRow)) || (x1_c >= x2_c);

    // length and row offset
    assign len_wide = x2_c - x1_c;
    assign prod     = row_s[RowW-1:0] * row_pitch;

    // register the span record
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg.row        <= row_s[RowW-1:0];
            span_reg.start      <= x1_c[RowW-1:0];
            span_reg.length     <= len_wide[LenW-1:0];
            span_reg.row_offset <= prod;
            span_reg.empty      <= empty;
            span_reg.last       <= last;
        end
    end

    assign span = span_reg;

endmodule

### rtl/filled_disc_span_rasterizer.sv
// top level of the filled disc span rasterizer: sequencer, registers and output word
//
// usage
//   s_* takes one disc request word; m_* gives 2r+1 span words per disc,
//   one per row from the top of the disc down, m_tlast on the bottom span.
//   m_tuser flags an empty span (off-screen or past row 4095); its row, start,
//   length and address are zero but it still keeps its place in the run.
//   cfg_* writes screen_width, screen_height, row_pitch and frame_base at
//   any time; cfg_ready is always high. write them only while idle.
// timing
//   s_tready is high only while no disc is in work. per row the shared
//   square-and-compare unit walks the half-width one step a cycle from the
//   previous row's value, then the clip unit clips the span and registers
//   row times pitch; the address add loads the output register when it is free.
// reset and stall
//   reset clears the sequencer and output valid and loads the register
//   defaults (640 x 480, pitch 2560, base 0). while m_tready is low the
//   finished span holds in the output register and the sequencer waits.
module filled_disc_span_rasterizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // center_x[12:0], center_y[25:13], radius[30:26], fill_color[62:31], zero[63]
    input  logic [fdsr_pkg::SDataW-1:0]      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // span_row[11:0], span_start[23:12], span_length[36:24],
    // span_address[68:37], span_color[100:69], zero[103:101]
    output logic [fdsr_pkg::MDataW-1:0]      m_tdata,
    // span_empty[0]
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdsr_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [fdsr_pkg::CfgDataW-1:0]    cfg_data
);
    import fdsr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic signed [CoordW-1:0] cx_reg;
    logic signed [CoordW-1:0] cy_reg;
    logic [RadW-1:0]          r_reg;
    logic [ColorW-1:0]        color_reg;
    logic signed [DyW-1:0]    dy_reg;
    logic [HwW-1:0]           hw_reg;
    logic [WidthW-1:0]        width_reg;
    logic [WidthW-1:0]        height_reg;
    logic [PitchW-1:0]        pitch_reg;
    logic [BaseW-1:0]         base_reg;
    logic                     m_tvalid_reg;
    logic [MDataW-1:0]        m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     m_tlast_reg;

    logic                     grow;
    logic [RadW-1:0]          dy_mag;
    logic [HwW-1:0]           cand;
    logic                     fits;
    logic                     row_done;
    logic                     is_last;
    logic                     out_free;
    span_t                    span;
    logic [AddrW-1:0]         addr;
    logic [MDataW-1:0]        tdata_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ResetWidth;
            height_reg <= ResetHeight;
            pitch_reg  <= ResetPitch;
            base_reg   <= ResetBase;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[WidthW-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[WidthW-1:0];
                REG_ROW_PITCH:     pitch_reg  <= cfg_data[PitchW-1:0];
                REG_FRAME_BASE:    base_reg   <= cfg_data[BaseW-1:0];
                default:           ;
            endcase
        end
    end

    // half-width walk: grows up to the center row, shrinks below it
    assign grow    = (dy_reg <= 0);
    assign dy_mag  = dy_reg[DyW-1] ? RadW'(-dy_reg) : dy_reg[RadW-1:0];
    assign cand    = grow ? (hw_reg + HwW'(1)) : hw_reg;
    assign is_last = (dy_reg == $signed({1'b0, r_reg}));

    fdsr_fit_unit u_fit (
        .cand   (cand),
        .dy_mag (dy_mag),
        .radius (r_reg),
        .fits   (fits)
    );

    assign row_done = (state_reg == ST_SEARCH) && (grow ? !fits : fits);

    fdsr_clip_unit u_clip (
        .clk           (clk),
        .load          (row_done),
        .center_x      (cx_reg),
        .center_y      (cy_reg),
        .dy            (dy_reg),
        .hw            (hw_reg),
        .last          (is_last),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .row_pitch     (pitch_reg),
        .span          (span)
    );

    // address add and output word packing
    assign addr = AddrW'(base_reg) + AddrW'(span.row_offset)
                + AddrW'({span.start, 2'b00});

    assign tdata_next = span.empty
        ? MDataW'({color_reg, AddrW'(0), LenW'(0), RowW'(0), RowW'(0)})
        : MDataW'({color_reg, addr, span.length, span.start, span.row});

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            r_reg        <= '0;
            color_reg    <= '0;
            dy_reg       <= '0;
            hw_reg       <= '0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            // drop the word once taken, unless a new span replaces it
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cx_reg    <= $signed(s_tdata[CoordW-1:0]);
                        cy_reg    <= $signed(s_tdata[2*CoordW-1:CoordW]);
                        r_reg     <= s_tdata[2*CoordW+RadW-1:2*CoordW];
                        color_reg <= s_tdata[2*CoordW+RadW+ColorW-1:2*CoordW+RadW];
                        dy_reg    <= DyW'(0) - $signed(DyW'({1'b0,
                                     s_tdata[2*CoordW+RadW-1:2*CoordW]}));
                        hw_reg    <= '0;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    priority if (row_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else if (grow)
                    begin
                        hw_reg <= hw_reg + HwW'(1);
                    end
                    else
                    begin
                        hw_reg <= hw_reg - HwW'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= tdata_next;
                        m_tuser_reg  <= span.empty;
                        m_tlast_reg  <= span.last;
                        if (span.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            dy_reg    <= dy_reg + DyW'(1);
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### tb/filled_disc_span_rasterizer_tb.sv
// self-checking testbench for the filled disc span rasterizer: directed and random discs
module filled_disc_span_rasterizer_tb;
    import fdsr_pkg::*;

    localparam int HoldCycles     = 600;
    localparam int IdleLimit      = 5000;
    localparam int RandomPerPhase = 72;

    // one span word as the block presents it
    typedef struct packed {
        logic [RowW-1:0]   row;
        logic [RowW-1:0]   start;
        logic [LenW-1:0]   length;
        logic [AddrW-1:0]  address;
        logic [ColorW-1:0] color;
        logic              empty;
        logic              last;
    } span_word_t;

    // own copy of the screen registers and the spans still owed by the block
    class disc_span_board;
        int unsigned width;
        int unsigned height;
        int unsigned pitch;
        int unsigned base;
        span_word_t  pending_spans[$];
        int          errors;

        function new();
            width  = 640;
            height = 480;
            pitch  = 2560;
            base   = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
            case (idx)
                REG_SCREEN_WIDTH:  width  = 32'(value[WidthW-1:0]);
                REG_SCREEN_HEIGHT: height = 32'(value[WidthW-1:0]);
                REG_ROW_PITCH:     pitch  = 32'(value[PitchW-1:0]);
                REG_FRAME_BASE:    base   = 32'(value[BaseW-1:0]);
                default: ;
            endcase
        endfunction

        // work out the 2r+1 clipped spans of one accepted disc
        function void note_disc(int cx, int cy, int radius, logic [ColorW-1:0] color);
            int         dy;
            int         hw;
            int         row;
            int         x1;
            int         x2;
            span_word_t s;
            for (dy = -radius; dy <= radius; dy++) begin
                hw = 0;
                while ((hw + 1) * (hw + 1) + dy * dy <= radius * radius)
                    hw++;
                row = cy + dy;
                x1  = cx - hw;
                x2  = cx + hw + 1;
                if (x1 < 0)
                    x1 = 0;
                if (x2 > int'(width))
                    x2 = int'(width);
                s       = '0;
                s.color = color;
                s.last  = (dy == radius);
                s.empty = (row < 0) || (row >= int'(height)) || (row > MaxRow) || (x1 >= x2);
                if (!s.empty)
                begin
                    s.row     = RowW'(row);
                    s.start   = RowW'(x1);
                    s.length  = LenW'(x2 - x1);
                    s.address = 32'(base) + 32'(row) * 32'(pitch) + 32'(x1) * 32'd4;
                end
                pending_spans.push_back(s);
            end
        endfunction

        function void compare(string field, logic [31:0] exp, logic [31:0] got);
            if (exp !== got)
            begin
                errors++;
                $display("%0t: span %s expected %0h actual %0h", $time, field, exp, got);
            end
        endfunction

        // match one span word against the oldest one owed
        function void check_span(span_word_t got);
            span_word_t exp;
            if (pending_spans.size() == 0)
            begin
                errors++;
                $display("%0t: span word with none expected, actual %h", $time, got);
                return;
            end
            exp = pending_spans.pop_front();
            compare("row", 32'(exp.row), 32'(got.row));
            compare("start", 32'(exp.start), 32'(got.start));
            compare("length", 32'(exp.length), 32'(got.length));
            compare("address", exp.address, got.address);
            compare("color", exp.color, got.color);
            compare("empty", 32'(exp.empty), 32'(got.empty));
            compare("last", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SDataW-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [MDataW-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    disc_span_board board = new();
    span_word_t     seen_span;
    int             idle_cycles = 0;
    bit             hold_off_req = 1'b0;
    bit             steady_flow = 1'b0;
    bit             burst_send = 1'b0;

    filled_disc_span_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short stalls, now and then a long one
    function automatic int stall_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    // coordinate near the visible area, sometimes anywhere in the field
    function automatic int pick_coord(int unsigned extent);
        int v;
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 8191)) - 4096;
        v = int'($urandom_range(0, extent + 80)) - 40;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // offer one disc request word and note it once taken
    task automatic send_disc(int cx, int cy, int radius, logic [ColorW-1:0] color);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, color, RadW'(radius), CoordW'(cy), CoordW'(cx)};
        do @(posedge clk); while (!s_tready);
        board.note_disc(cx, cy, radius, color);
        gap = 0;
        if (!steady_flow && !burst_send && $urandom_range(0, 99) >= 55)
            gap = stall_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every owed span is back
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (board.pending_spans.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, value);
    endtask

    // new screen setup, only once the block is idle
    task automatic set_screen(int unsigned w, int unsigned h, int unsigned p, int unsigned b);
        settle_block();
        write_reg(REG_SCREEN_WIDTH, CfgDataW'(w));
        write_reg(REG_SCREEN_HEIGHT, CfgDataW'(h));
        write_reg(REG_ROW_PITCH, CfgDataW'(p));
        write_reg(REG_FRAME_BASE, CfgDataW'(b));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_screen(int unsigned max_w, int unsigned max_h);
        set_screen($urandom_range(1, max_w), $urandom_range(1, max_h),
                   $urandom_range(4, 16384), $urandom_range(0, 30'h3FFF_FFFF));
    endtask

    task automatic random_discs(int count);
        int radius;
        repeat (count)
        begin
            if ($urandom_range(0, 2) == 0)
                radius = $urandom_range(0, 31);
            else
                radius = $urandom_range(0, 9);
            send_disc(pick_coord(board.width), pick_coord(board.height), radius, $urandom);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else if (steady_flow || $urandom_range(0, 99) < 60)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (stall_len()) @(posedge clk);
            end
        end
    end

    // span monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_span.row     = m_tdata[11:0];
            seen_span.start   = m_tdata[23:12];
            seen_span.length  = m_tdata[36:24];
            seen_span.address = m_tdata[68:37];
            seen_span.color   = m_tdata[100:69];
            seen_span.empty   = m_tuser;
            seen_span.last    = m_tlast;
            board.check_span(seen_span);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SCREEN_WIDTH;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset screen: single pixel, full disc, clipping on every edge
        send_disc(100, 100, 0, 32'h0000_0000);
        send_disc(320, 240, 31, 32'hFFFF_FFFF);
        send_disc(0, 0, 31, 32'hA5A5_A5A5);
        send_disc(639, 479, 3, 32'h5A5A_5A5A);
        send_disc(-31, 240, 31, 32'h1234_5678);
        send_disc(-1, 10, 0, 32'h8765_4321);
        send_disc(640, 10, 0, 32'hDEAD_BEEF);
        send_disc(670, 100, 31, 32'h0F0F_0F0F);
        send_disc(-4096, -4096, 5, 32'hF0F0_F0F0);
        send_disc(4095, 4095, 5, 32'h0000_0001);
        send_disc(50, -1, 1, 32'h8000_0000);
        send_disc(50, 480, 1, 32'h7FFF_FFFF);

        // largest screen, top base address
        set_screen(4096, 4096, 16384, 30'h3FFF_FFFF);
        send_disc(4095, 4095, 31, 32'hCAFE_F00D);
        send_disc(4080, 4090, 17, 32'h0BAD_CAFE);
        send_disc(0, 0, 0, 32'h1111_1111);

        // one-pixel screen, smallest pitch
        set_screen(1, 1, 4, 0);
        send_disc(0, 0, 0, 32'h2222_2222);
        send_disc(0, 0, 2, 32'h3333_3333);
        send_disc(1, 1, 1, 32'h4444_4444);

        // zero-sized screen, every span empty
        set_screen(0, 0, 2560, 123);
        send_disc(5, 5, 2, 32'h5555_5555);

        // height past the row field, rows above 4095 come out empty
        set_screen(8191, 8191, 4, 0);
        send_disc(4090, 4090, 10, 32'h6666_6666);
        send_disc(4095, 4095, 31, 32'h7777_7777);

        // random discs on the reset screen
        set_screen(640, 480, 2560, 0);
        random_discs(RandomPerPhase);

        // long receiver hold-off with back-to-back requests, then a full pause
        random_screen(4096, 4096);
        hold_off_req = 1'b1;
        burst_send   = 1'b1;
        random_discs(20);
        burst_send   = 1'b0;
        settle_block();
        random_discs(RandomPerPhase - 20);

        // tiny screens, heavy clipping
        random_screen(64, 64);
        random_discs(RandomPerPhase);

        // no gaps on either side
        random_screen(4096, 4096);
        steady_flow = 1'b1;
        random_discs(RandomPerPhase);
        steady_flow = 1'b0;

        // widest screen with rows past the field
        set_screen(4096, 8191, 16384, 30'h3FFF_FFFF);
        random_discs(RandomPerPhase);

        settle_block();
        if (board.errors == 0 && board.pending_spans.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
